// File: src/cmps_pkg.sv
`default_nettype none

package cmps_pkg;

  localparam int MAX_SIDE_DEF     = 256;
  localparam int MAX_CHANNELS_DEF = 4;

  localparam int POS_W   = 8;   // row / col port width
  localparam int SIDE_W  = 9;   // side_size register width
  localparam int ITER_W  = 10;  // iteration_count register width
  localparam int PIXEL_W = 32;  // pixel port width
  localparam int CFG_W   = 10;  // config data width (widest register)

  // Cells in the map ring; a token steps once per cell it passes.
  localparam int RING_CELLS = 4;

  localparam logic REG_SIDE_SIZE  = 1'b0;
  localparam logic REG_ITER_COUNT = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1);

  // Position token circulating through the ring
  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ITER_W-1:0] left;
  } cmps_tok_t;

endpackage

`default_nettype wire

// File: src/cmps_ram.sv
`default_nettype none

module cmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/cmps_cell.sv
`default_nettype none

module cmps_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [cmps_pkg::SIDE_W-1:0]   side,
  input  wire cmps_pkg::cmps_tok_t           tok_in,
  output cmps_pkg::cmps_tok_t                tok_out
);

  import cmps_pkg::*;

  logic [SIDE_W-1:0] sum_r;
  logic [SIDE_W-1:0] sum_c;
  logic [POS_W-1:0]  row_next;
  logic [POS_W-1:0]  col_next;

  // (r + c) mod n, then (r + 2c) mod n as (new_r + c) mod n; both sums stay below 2n
  always_comb begin
    sum_r    = {1'b0, tok_in.row} + {1'b0, tok_in.col};
    row_next = (sum_r >= side) ? POS_W'(sum_r - side) : POS_W'(sum_r);
    sum_c    = {1'b0, row_next} + {1'b0, tok_in.col};
    col_next = (sum_c >= side) ? POS_W'(sum_c - side) : POS_W'(sum_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.row  <= row_next;
    tok_out.col  <= col_next;
    tok_out.left <= tok_in.left - ITER_W'(1);
  end

endmodule

`default_nettype wire

// File: src/cat_map_pixel_scrambler.sv
`default_nettype none
// Channel   Handshake                   Payload
// in        in_valid / in_stall         action, row, col, pixel_in
// out       out_valid / out_stall       pixel_out, out_of_range
// cfg       cfg_we (no wait)            cfg_index, cfg_data
//
// A load does one cat-map step per cycle as the position token runs around the
// ring of cells, then writes the store. A read passes the store's read register
// and the output register; a read outside the image only the output register.
// Reset (rst, synchronous) clears control state; the store is not cleared.
// Loads are accepted while a result waits stalled; reads wait for the output slot.

module cat_map_pixel_scrambler #(
  parameter int MAX_CHANNELS = cmps_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [cmps_pkg::CFG_W-1:0]    cfg_data,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [cmps_pkg::POS_W-1:0]    row,
  input  wire logic [cmps_pkg::POS_W-1:0]    col,
  input  wire logic [cmps_pkg::PIXEL_W-1:0]  pixel_in,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [cmps_pkg::PIXEL_W-1:0]  pixel_out,
  output logic                               out_of_range
);

  import cmps_pkg::*;

  localparam int MAX_SIDE = MAX_SIDE_DEF;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int STORE_W  = 8 * MAX_CHANNELS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state, state_next;

  logic [SIDE_W-1:0]  side_size;
  logic [ITER_W-1:0]  iteration_count;
  logic [SIDE_W-1:0]  n;

  logic [STORE_W-1:0] pixel_hold;

  cmps_tok_t          tok_d [RING_CELLS];
  cmps_tok_t          tok_q [RING_CELLS];

  logic               accept;
  logic               outside;
  logic               is_load;
  logic               inject;
  logic               direct_wr;
  logic               done;
  logic [POS_W-1:0]   done_row;
  logic [POS_W-1:0]   done_col;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [STORE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [STORE_W-1:0] ram_rdata;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c);
    int a;
    a = int'(r) * MAX_SIDE + int'(c);
    return ADDR_W'(a);
  endfunction

  // Clamp side size into [2, MAX_SIDE]
  always_comb begin
    if (side_size < SIDE_W'(2)) begin
      n = SIDE_W'(2);
    end else if (int'(side_size) > MAX_SIDE) begin
      n = SIDE_W'(MAX_SIDE);
    end else begin
      n = side_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_size       <= SIDE_RESET;
      iteration_count <= ITER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIDE_SIZE:  side_size       <= cfg_data[SIDE_W-1:0];
        REG_ITER_COUNT: iteration_count <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads need the output slot free (or emptied this cycle)
  assign in_stall  = rst || (state != ST_IDLE) || (action && out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign outside   = ({1'b0, row} >= n) || ({1'b0, col} >= n);
  assign is_load   = accept && !action && !outside;
  assign inject    = is_load && (iteration_count != '0);
  assign direct_wr = is_load && (iteration_count == '0);

  // Ring: a token moves on only while steps remain
  always_comb begin
    if (inject) begin
      tok_d[0].valid = 1'b1;
      tok_d[0].row   = row;
      tok_d[0].col   = col;
      tok_d[0].left  = iteration_count;
    end else begin
      tok_d[0]       = tok_q[RING_CELLS-1];
      tok_d[0].valid = tok_q[RING_CELLS-1].valid && (tok_q[RING_CELLS-1].left != '0);
    end
    for (int i = 1; i < RING_CELLS; i++) begin
      tok_d[i]       = tok_q[i-1];
      tok_d[i].valid = tok_q[i-1].valid && (tok_q[i-1].left != '0);
    end
  end

  for (genvar g = 0; g < RING_CELLS; g++) begin : g_cell
    cmps_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .side    (n),
      .tok_in  (tok_d[g]),
      .tok_out (tok_q[g])
    );
  end

  // At most one token lives in the ring, so OR the finished one out
  always_comb begin
    done     = 1'b0;
    done_row = '0;
    done_col = '0;
    for (int i = 0; i < RING_CELLS; i++) begin
      if (tok_q[i].valid && (tok_q[i].left == '0)) begin
        done     = 1'b1;
        done_row = done_row | tok_q[i].row;
        done_col = done_col | tok_q[i].col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inject) begin
      pixel_hold <= pixel_in[STORE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (inject) begin
          state_next = ST_RUN;
        end else if (accept && action && !outside) begin
          state_next = ST_READ;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ram_we    = direct_wr || ((state == ST_RUN) && done);
  assign ram_waddr = direct_wr ? addr_of(row, col) : addr_of(done_row, done_col);
  assign ram_wdata = direct_wr ? pixel_in[STORE_W-1:0] : pixel_hold;
  assign ram_raddr = addr_of(row, col);

  cmps_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_READ) begin
        out_valid <= 1'b1;
      end else if (accept && action && outside) begin
        out_valid <= 1'b1;
      end
    end
    if (state == ST_READ) begin
      pixel_out    <= PIXEL_W'(ram_rdata);
      out_of_range <= 1'b0;
    end else if (accept && action && outside) begin
      pixel_out    <= '0;
      out_of_range <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/cmps_checker.sv
`default_nettype none

module cmps_checker #(
  parameter int MAX_CHANNELS = 4
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        action,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] pixel_out,
  input wire logic        out_of_range
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(out_of_range))
    else $error("stalled result changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> pixel_out == 32'd0)
    else $error("out-of-range result carries pixel data");

  // An accepted read is either answered at once or keeps the input stalled
  a_read_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action |=> out_valid || in_stall)
    else $error("accepted read lost");

  a_read_blocked: assert property (@(posedge clk) disable iff (rst)
    in_valid && action && out_valid && out_stall |-> in_stall)
    else $error("read accepted while output slot is blocked");

  a_chan_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_out >> (8 * MAX_CHANNELS)) == 32'd0)
    else $error("unused pixel channels not zero");

endmodule

bind cat_map_pixel_scrambler cmps_checker #(.MAX_CHANNELS(MAX_CHANNELS)) u_cmps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .action       (action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_out    (pixel_out),
  .out_of_range (out_of_range)
);

`default_nettype wire
